@@ rtl/jts_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// jts_pkg
// Shared widths, token kind codes and the token record types of the
// json token scanner.
// ---------------------------------------------------------------------------
package jts_pkg;

   localparam int OFFSET_BITS   = 20;
   localparam int POSITION_BITS = 16;
   localparam int KIND_BITS     = 4;
   localparam int QUEUE_DEPTH   = 4;

   // token kind codes
   localparam logic [KIND_BITS-1:0] KIND_END     = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_LBRACK  = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_RBRACK  = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_COLON   = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_COMMA   = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_STRING  = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_TRUE    = 4'd9;
   localparam logic [KIND_BITS-1:0] KIND_FALSE   = 4'd10;
   localparam logic [KIND_BITS-1:0] KIND_NULL    = 4'd11;
   localparam logic [KIND_BITS-1:0] KIND_INVALID = 4'd12;

   // one token as it travels from scanner to output
   typedef struct packed {
      logic [KIND_BITS-1:0]     kind;
      logic [OFFSET_BITS-1:0]   start;
      logic [OFFSET_BITS-1:0]   len;
      logic [POSITION_BITS-1:0] line;
      logic [POSITION_BITS-1:0] column;
      logic                     last;
   } token_type;

   // tokens produced by one accepted beat, first in tok0
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

endpackage
`default_nettype wire

@@ rtl/jts_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// jts_front
// Scanner front: takes one text beat a cycle while accept is high, updates the lexer state and
// hands zero, one or two finished tokens to the queue.
// ---------------------------------------------------------------------------
module jts_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          text_byte,
   input  wire logic                text_end,
   output jts_pkg::push_type        push
);

   localparam int OB = jts_pkg::OFFSET_BITS;
   localparam int PB = jts_pkg::POSITION_BITS;

   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;
   localparam logic [7:0] CHAR_PLUS      = 8'h2B;
   localparam logic [7:0] CHAR_DOT       = 8'h2E;
   localparam logic [7:0] CHAR_LOWER_E   = 8'h65;
   localparam logic [7:0] CHAR_UPPER_E   = 8'h45;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHAR_LBRACK    = 8'h5B;
   localparam logic [7:0] CHAR_RBRACK    = 8'h5D;
   localparam logic [7:0] CHAR_COLON     = 8'h3A;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_NUL       = 8'h00;

   typedef enum logic [7:0] {
      MODE_IDLE    = 8'b0000_0001,
      MODE_SLASH   = 8'b0000_0010,
      MODE_COMMENT = 8'b0000_0100,
      MODE_STRING  = 8'b0000_1000,
      MODE_ESC     = 8'b0001_0000,
      MODE_NUMBER  = 8'b0010_0000,
      MODE_WORD    = 8'b0100_0000,
      MODE_DONE    = 8'b1000_0000
   } mode_type;

   // character classes
   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
   endfunction

   function automatic logic is_num_char(input logic [7:0] b);
      return is_digit(b) || (b == CHAR_DOT) || (b == CHAR_LOWER_E) ||
             (b == CHAR_UPPER_E) || (b == CHAR_PLUS) || (b == CHAR_MINUS);
   endfunction

   // keyword table: true, false, null
   function automatic logic [7:0] word_char(input logic [1:0] k, input logic [2:0] idx);
      logic [7:0] c;
      case ({k, idx})
         5'b00_000: c = 8'h74; // t
         5'b00_001: c = 8'h72; // r
         5'b00_010: c = 8'h75; // u
         5'b00_011: c = 8'h65; // e
         5'b01_000: c = 8'h66; // f
         5'b01_001: c = 8'h61; // a
         5'b01_010: c = 8'h6C; // l
         5'b01_011: c = 8'h73; // s
         5'b01_100: c = 8'h65; // e
         5'b10_000: c = 8'h6E; // n
         5'b10_001: c = 8'h75; // u
         5'b10_010: c = 8'h6C; // l
         5'b10_011: c = 8'h6C; // l
         default:   c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] word_size(input logic [1:0] k);
      return (k == 2'd1) ? 3'd5 : 3'd4;
   endfunction

   function automatic logic [3:0] word_kind(input logic [1:0] k);
      logic [3:0] r;
      case (k)
         2'd0:    r = jts_pkg::KIND_TRUE;
         2'd1:    r = jts_pkg::KIND_FALSE;
         2'd2:    r = jts_pkg::KIND_NULL;
         default: r = jts_pkg::KIND_INVALID;
      endcase
      return r;
   endfunction

   // drop keyword candidates that no longer fit the letter at position len
   function automatic logic [2:0] match_letter(input logic [2:0] live,
                                               input logic [OB-1:0] len,
                                               input logic [7:0] b);
      logic [2:0] r;
      r = live;
      for (int k = 0; k < 3; k++) begin
         if (live[k]) begin
            if ((len >= OB'(word_size(2'(k)))) || (word_char(2'(k), len[2:0]) != b)) begin
               r[k] = 1'b0;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [OB-1:0] off_inc(input logic [OB-1:0] v);
      return (v == {OB{1'b1}}) ? v : v + OB'(1);
   endfunction

   function automatic logic [PB-1:0] pos_inc(input logic [PB-1:0] v);
      return (v == {PB{1'b1}}) ? v : v + PB'(1);
   endfunction

   mode_type      mode_ff, mode_in;
   logic [OB-1:0] off_ff, off_in;
   logic [PB-1:0] line_ff, line_in;
   logic [PB-1:0] col_ff, col_in;
   logic [OB-1:0] tstart_ff, tstart_in;
   logic [OB-1:0] tlen_ff, tlen_in;
   logic [PB-1:0] tline_ff, tline_in;
   logic [PB-1:0] tcol_ff, tcol_in;
   logic [2:0]    wmatch_ff, wmatch_in;

   logic                end_flag;
   logic                cls_open;
   logic                use_cls;
   logic                do_idle;
   logic                do_adv;
   logic                idl_valid;
   logic [3:0]          word_res;
   jts_pkg::token_type  cls_tok;
   jts_pkg::token_type  idl_tok;
   jts_pkg::token_type  end_tok;
   jts_pkg::push_type   push_c;

   assign end_flag = text_end || (text_byte == CHAR_NUL);

   // keyword verdict for a closing letter run
   always_comb begin
      word_res = jts_pkg::KIND_INVALID;
      for (int k = 2; k >= 0; k--) begin
         if (wmatch_ff[k] && (tlen_ff == OB'(word_size(2'(k))))) begin
            word_res = word_kind(2'(k));
         end
      end
   end

   // token closed by the current beat, if one is open
   always_comb begin
      cls_open = 1'b1;
      cls_tok  = '{kind: jts_pkg::KIND_INVALID, start: tstart_ff, len: tlen_ff,
                   line: tline_ff, column: tcol_ff, last: 1'b0};
      case (mode_ff)
         MODE_SLASH:  cls_tok.len = OB'(1);
         MODE_STRING: cls_tok.kind = jts_pkg::KIND_STRING;
         MODE_ESC:    cls_tok.kind = jts_pkg::KIND_STRING;
         MODE_NUMBER: cls_tok.kind = jts_pkg::KIND_NUMBER;
         MODE_WORD:   cls_tok.kind = word_res;
         default:     cls_open = 1'b0;
      endcase
   end

   assign end_tok = '{kind: jts_pkg::KIND_END, start: off_ff, len: '0,
                      line: line_ff, column: col_ff, last: 1'b0};

   // next lexer state and produced tokens
   always_comb begin
      mode_in   = mode_ff;
      off_in    = off_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      tstart_in = tstart_ff;
      tlen_in   = tlen_ff;
      tline_in  = tline_ff;
      tcol_in   = tcol_ff;
      wmatch_in = wmatch_ff;
      use_cls   = 1'b0;
      do_idle   = 1'b0;
      do_adv    = 1'b0;
      idl_valid = 1'b0;
      idl_tok   = '{kind: jts_pkg::KIND_INVALID, start: off_ff, len: OB'(1),
                    line: line_ff, column: col_ff, last: 1'b0};
      push_c    = '0;

      if (mode_ff == MODE_DONE) begin
         if (end_flag) begin
            push_c.count = 2'd1;
            push_c.tok0  = end_tok;
         end
      end else if (end_flag) begin
         mode_in = MODE_DONE;
         if (cls_open) begin
            push_c.count = 2'd2;
            push_c.tok0  = cls_tok;
            push_c.tok1  = end_tok;
         end else begin
            push_c.count = 2'd1;
            push_c.tok0  = end_tok;
         end
      end else begin
         case (mode_ff)
            MODE_SLASH: begin
               if (text_byte == CHAR_SLASH) begin
                  mode_in = MODE_COMMENT;
                  do_adv  = 1'b1;
               end else begin
                  use_cls = 1'b1;
                  do_idle = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (text_byte == CHAR_LF) begin
                  mode_in = MODE_IDLE;
               end
               do_adv = 1'b1;
            end
            MODE_STRING: begin
               if (text_byte == CHAR_QUOTE) begin
                  use_cls = 1'b1;
                  mode_in = MODE_IDLE;
               end else begin
                  tlen_in = off_inc(tlen_ff);
                  if (text_byte == CHAR_BACKSLASH) begin
                     mode_in = MODE_ESC;
                  end
               end
               col_in = pos_inc(col_ff);
               off_in = off_inc(off_ff);
            end
            MODE_ESC: begin
               tlen_in = off_inc(tlen_ff);
               col_in  = pos_inc(col_ff);
               off_in  = off_inc(off_ff);
               mode_in = MODE_STRING;
            end
            MODE_NUMBER: begin
               if (is_num_char(text_byte)) begin
                  tlen_in = off_inc(tlen_ff);
                  do_adv  = 1'b1;
               end else begin
                  use_cls = 1'b1;
                  do_idle = 1'b1;
               end
            end
            MODE_WORD: begin
               if (is_alpha(text_byte)) begin
                  wmatch_in = match_letter(wmatch_ff, tlen_ff, text_byte);
                  tlen_in   = off_inc(tlen_ff);
                  do_adv    = 1'b1;
               end else begin
                  use_cls = 1'b1;
                  do_idle = 1'b1;
               end
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase

         // byte scanned as the start of something new
         if (do_idle) begin
            mode_in = MODE_IDLE;
            do_adv  = 1'b1;
            if (is_space(text_byte)) begin
               idl_valid = 1'b0;
            end else if (text_byte == CHAR_LBRACE) begin
               idl_valid    = 1'b1;
               idl_tok.kind = jts_pkg::KIND_LBRACE;
            end else if (text_byte == CHAR_RBRACE) begin
               idl_valid    = 1'b1;
               idl_tok.kind = jts_pkg::KIND_RBRACE;
            end else if (text_byte == CHAR_LBRACK) begin
               idl_valid    = 1'b1;
               idl_tok.kind = jts_pkg::KIND_LBRACK;
            end else if (text_byte == CHAR_RBRACK) begin
               idl_valid    = 1'b1;
               idl_tok.kind = jts_pkg::KIND_RBRACK;
            end else if (text_byte == CHAR_COLON) begin
               idl_valid    = 1'b1;
               idl_tok.kind = jts_pkg::KIND_COLON;
            end else if (text_byte == CHAR_COMMA) begin
               idl_valid    = 1'b1;
               idl_tok.kind = jts_pkg::KIND_COMMA;
            end else if (text_byte == CHAR_SLASH) begin
               tstart_in = off_ff;
               tline_in  = line_ff;
               tcol_in   = col_ff;
               mode_in   = MODE_SLASH;
            end else if (text_byte == CHAR_QUOTE) begin
               tstart_in = off_inc(off_ff);
               tline_in  = line_ff;
               tcol_in   = col_ff;
               tlen_in   = '0;
               mode_in   = MODE_STRING;
            end else if (is_digit(text_byte) || (text_byte == CHAR_MINUS)) begin
               tstart_in = off_ff;
               tline_in  = line_ff;
               tcol_in   = col_ff;
               tlen_in   = OB'(1);
               mode_in   = MODE_NUMBER;
            end else if (is_alpha(text_byte)) begin
               tstart_in = off_ff;
               tline_in  = line_ff;
               tcol_in   = col_ff;
               wmatch_in = match_letter(3'b111, '0, text_byte);
               tlen_in   = OB'(1);
               mode_in   = MODE_WORD;
            end else begin
               idl_valid = 1'b1;
            end
         end

         // position advance over a scanned byte
         if (do_adv) begin
            off_in = off_inc(off_ff);
            if (text_byte == CHAR_LF) begin
               line_in = pos_inc(line_ff);
               col_in  = PB'(1);
            end else begin
               col_in = pos_inc(col_ff);
            end
         end

         // pack closed and new tokens in order
         if (use_cls && idl_valid) begin
            push_c.count = 2'd2;
            push_c.tok0  = cls_tok;
            push_c.tok1  = idl_tok;
         end else if (use_cls) begin
            push_c.count = 2'd1;
            push_c.tok0  = cls_tok;
         end else if (idl_valid) begin
            push_c.count = 2'd1;
            push_c.tok0  = idl_tok;
         end
      end

      // mark last token of the beat
      if (push_c.count == 2'd2) begin
         push_c.tok1.last = 1'b1;
      end else if (push_c.count == 2'd1) begin
         push_c.tok0.last = 1'b1;
      end

      if (!accept) begin
         push_c.count = 2'd0;
      end
   end

   assign push = push_c;

   // lexer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         off_ff    <= '0;
         line_ff   <= PB'(1);
         col_ff    <= PB'(1);
         tstart_ff <= '0;
         tlen_ff   <= '0;
         tline_ff  <= PB'(1);
         tcol_ff   <= PB'(1);
         wmatch_ff <= 3'b111;
      end else if (accept) begin
         mode_ff   <= mode_in;
         off_ff    <= off_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         tstart_ff <= tstart_in;
         tlen_ff   <= tlen_in;
         tline_ff  <= tline_in;
         tcol_ff   <= tcol_in;
         wmatch_ff <= wmatch_in;
      end
   end

`ifndef SYNTHESIS
   // a finished scanner turns text bytes into nothing
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && (mode_ff == MODE_DONE) && !end_flag) |-> (push.count == 2'd0))
      else $error("text byte after end produced a token");

   // an end mark always leaves the scanner finished
   a_end_done: assert property (@(posedge clock) disable iff (reset)
      (accept && end_flag) |=> (mode_ff == MODE_DONE))
      else $error("end mark did not finish the scan");

   // only the final token of a pair is marked last
   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.tok1.last && !push.tok0.last))
      else $error("bad last flag on token pair");

   // no more than two tokens per beat
   a_push_max: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd3))
      else $error("more than two tokens from one beat");
`endif

endmodule
`default_nettype wire

@@ rtl/jts_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// jts_queue
// Token queue between scanner front and output stage: takes up to two
// tokens a cycle, gives out one.
// ---------------------------------------------------------------------------
module jts_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire jts_pkg::push_type   push,
   output logic                     room,
   output logic                     head_valid,
   output jts_pkg::token_type       head_tok,
   input  wire logic                pop
);

   localparam int DEPTH      = jts_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   jts_pkg::token_type    entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [PTR_BITS-1:0]   wr_next;

   assign wr_next    = wr_ptr_ff + PTR_BITS'(1);
   assign room       = (count_ff <= COUNT_BITS'(DEPTH - 2));
   assign head_valid = (count_ff != '0);
   assign head_tok   = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + COUNT_BITS'(push.count) - COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.tok1;
      end
   end

endmodule
`default_nettype wire

@@ rtl/jts_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// jts_back
// Output stage: registers one token and presents it on the result channel,
// refilling from the queue as beats leave.
// ---------------------------------------------------------------------------
module jts_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire jts_pkg::token_type  head_tok,
   output logic                     pop,
   output logic                     out_valid,
   output jts_pkg::token_type       out_tok,
   input  wire logic                out_ready
);

   logic               valid_ff, valid_in;
   jts_pkg::token_type tok_ff;

   // load when the register is empty or its beat leaves
   assign pop      = head_valid && (!valid_ff || out_ready);
   assign valid_in = pop || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         tok_ff <= head_tok;
      end
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;

endmodule
`default_nettype wire

@@ rtl/json_token_scanner.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// json_token_scanner
// Streaming JSON lexer: one text byte per beat in, tokens out.
// ---------------------------------------------------------------------------
// The scanner takes one text byte (or end mark) per clock cycle and updates
// its lexer state in that same cycle; each beat gives zero, one or two tokens
// with kind, start offset, length, line and column. Tokens pass through a
// four-entry queue and a registered output stage before they reach the
// result channel. req_ready is high while the queue has at least two free
// entries; the output drains one token per cycle, so input runs at one
// byte per cycle except when two-token beats or result stalls fill the
// queue. After the end mark the scanner stays finished until reset: text
// bytes are taken and dropped, and each further end mark repeats the end
// token.
// ---------------------------------------------------------------------------
module json_token_scanner (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [7:0]                          req_text_byte,
   input  wire logic                                req_text_end,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [jts_pkg::KIND_BITS-1:0]            rsp_token_kind,
   output logic [jts_pkg::OFFSET_BITS-1:0]          rsp_start_offset,
   output logic [jts_pkg::OFFSET_BITS-1:0]          rsp_token_length,
   output logic [jts_pkg::POSITION_BITS-1:0]        rsp_line_number,
   output logic [jts_pkg::POSITION_BITS-1:0]        rsp_column_number,
   output logic                                     rsp_last_of_run
);

   logic               accept;
   logic               room;
   logic               head_valid;
   logic               pop;
   jts_pkg::push_type  push;
   jts_pkg::token_type head_tok;
   jts_pkg::token_type out_tok;

   assign req_ready = room;
   assign accept    = req_valid && room;

   // scanner front
   jts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_text_byte),
      .text_end  (req_text_end),
      .push      (push)
   );

   // token queue
   jts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .head_valid (head_valid),
      .head_tok   (head_tok),
      .pop        (pop)
   );

   // output stage
   jts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_tok   (head_tok),
      .pop        (pop),
      .out_valid  (rsp_valid),
      .out_tok    (out_tok),
      .out_ready  (rsp_ready)
   );

   assign rsp_token_kind    = out_tok.kind;
   assign rsp_start_offset  = out_tok.start;
   assign rsp_token_length  = out_tok.len;
   assign rsp_line_number   = out_tok.line;
   assign rsp_column_number = out_tok.column;
   assign rsp_last_of_run   = out_tok.last;

endmodule
`default_nettype wire
